[rtl/core/wpfc_pkg.sv]
// Shared types, widths and constants of the windowed PID force controller.
package wpfc_pkg;

    // Field widths
    localparam int POS_W      = 32;
    localparam int GAIN_W     = 24;
    localparam int STEP_W     = 9;
    localparam int FORCE_W    = 17;
    localparam int CFG_ADDR_W = 3;
    localparam int S_TDATA_W  = 80;
    localparam int M_TDATA_W  = 24;

    // Samples per gait step; larger step indices saturate to the last sample
    localparam int STEP_SAMPLES = 512;

    // Shared multiplier and datapath widths
    localparam int MUL_A_W = 25;
    localparam int MUL_B_W = 32;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int SUM_W   = MUL_P_W + 2;
    localparam int CMD_W   = 14;
    localparam int DIVN_W  = 23;
    localparam int QUO_W   = 17;
    localparam int REM_W   = 24;

    // Q16.16 constants
    localparam int                         Q_SHIFT     = 16;
    localparam logic signed [POS_W:0]      SUM_MAX     = 33'sd262144000;
    localparam logic signed [POS_W:0]      SUM_MIN     = -33'sd262144000;
    localparam logic signed [SUM_W-1:0]    CMD_MAX     = 59'sd6554;
    localparam logic signed [SUM_W-1:0]    CMD_MIN     = -59'sd6554;
    localparam logic signed [FORCE_W-1:0]  FORCE_FLOOR = -17'sd32768;

    // Divide by 100: multiply by ceil(2^29 / 100), shift, one-step fix-up
    localparam logic signed [MUL_A_W-1:0] RECIP_100   = 25'sd5368710;
    localparam int                        RECIP_SHIFT = 29;
    localparam logic signed [REM_W-1:0]   SCALE_DIV   = 24'sd100;

    // Register map
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_GAIN_P       = 3'd0,
        CFG_GAIN_D       = 3'd1,
        CFG_GAIN_I       = 3'd2,
        CFG_WINDOW_START = 3'd3,
        CFG_WINDOW_END   = 3'd4
    } cfg_index_t;

    // Sequencer states, one-hot
    typedef enum logic [11:0] {
        ST_IDLE  = 12'b0000_0000_0001,
        ST_ERR   = 12'b0000_0000_0010,
        ST_STATE = 12'b0000_0000_0100,
        ST_MP    = 12'b0000_0000_1000,
        ST_MD    = 12'b0000_0001_0000,
        ST_MI    = 12'b0000_0010_0000,
        ST_SUM   = 12'b0000_0100_0000,
        ST_CMD   = 12'b0000_1000_0000,
        ST_MS    = 12'b0001_0000_0000,
        ST_MQ    = 12'b0010_0000_0000,
        ST_DIV   = 12'b0100_0000_0000,
        ST_FIX   = 12'b1000_0000_0000
    } state_t;

    // Operand pair for the shared multiplier
    typedef struct packed {
        logic signed [MUL_A_W-1:0] a;
        logic signed [MUL_B_W-1:0] b;
    } mul_op_t;

    // Saturate a 33-bit difference to 32 bits
    function automatic logic signed [POS_W-1:0] sat32(input logic signed [POS_W:0] v);
        logic signed [POS_W-1:0] r;
        if (v[POS_W] != v[POS_W-1]) begin
            r = v[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end else begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

endpackage

[rtl/core/wpfc_mul.sv]
// Shared signed multiplier with registered product.
module wpfc_mul import wpfc_pkg::*; (
    input  logic                      aclk,
    input  mul_op_t                   op,
    output logic signed [MUL_P_W-1:0] prod_reg
);

    logic signed [MUL_P_W-1:0] prod_next;

    // Full-width signed product
    assign prod_next = MUL_P_W'(op.a) * MUL_P_W'(op.b);

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

endmodule

[rtl/core/windowed_pid_force_controller.sv]
// Top level of the windowed PID force controller.
// Each request carries a target and a measured position (signed Q16.16) and a gait-step
// index, and yields one force_command (signed Q1.16, 17 bits). Once a request is
// accepted, the block is not ready for another until its sequencer is back in idle: the
// sequencer drives one shared 25x32 multiplier through the three PID gain
// products, the step scaling and a reciprocal divide by 100, one product per cycle.
// The result sits in an output register, so the next request is accepted while it
// waits; the sequencer only stalls in its last step if the previous result has not been
// taken. The error history and the clamped error sum reset to zero; gains and window
// bounds reset to zero. The user must write them through the cfg port only while the
// block is idle; the block itself does not enforce this.
module windowed_pid_force_controller import wpfc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input requests
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [31:0] position_target, [63:32] position_measured,
                                             // [72:64] step_index, [79:73] zero
    // Results
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [16:0] force_command, [23:17] zero
    // Configuration writes
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [GAIN_W-1:0]     cfg_wdata
);

    state_t state_reg, state_next;

    // Configuration
    logic [GAIN_W-1:0] gain_p_reg, gain_d_reg, gain_i_reg;
    logic [STEP_W-1:0] win_start_reg, win_end_reg;

    // Controller state
    logic signed [POS_W-1:0] prev_err_reg, err_acc_reg;

    // Working registers
    logic signed [POS_W-1:0]   target_reg, measured_reg;
    logic [STEP_W-1:0]         step_reg;
    logic                      win_reg;
    logic signed [POS_W-1:0]   err_reg, chg_reg;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic signed [CMD_W-1:0]   cmd_reg, cmd_next;
    logic signed [DIVN_W-1:0]  num_reg;
    logic signed [QUO_W-1:0]   quo_reg;

    // Output register
    logic                      out_valid_reg;
    logic signed [FORCE_W-1:0] force_reg, force_next;

    // Shared multiplier
    mul_op_t                   mul_op;
    logic signed [MUL_P_W-1:0] prod_reg;

    wpfc_mul u_mul (
        .aclk     (aclk),
        .op       (mul_op),
        .prod_reg (prod_reg)
    );

    logic                      in_fire, out_fire, fix_go;
    logic [STEP_W-1:0]         step_sat;
    logic signed [POS_W-1:0]   err_new, chg_new;
    logic signed [POS_W:0]     acc_sum;
    logic signed [POS_W-1:0]   acc_new;
    logic signed [SUM_W-1:0]   prod_ext, sum_neg, sum_shift;
    logic signed [REM_W-1:0]   quo_ext, num_ext, hund_q, rem;
    logic signed [QUO_W-1:0]   quo_fix;

    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = out_valid_reg && m_tready;
    assign fix_go   = !out_valid_reg || m_tready;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-FORCE_W){1'b0}}, force_reg};

    // Step saturation and error terms
    assign step_sat = ({{(32-STEP_W){1'b0}}, step_reg} >= STEP_SAMPLES)
                    ? STEP_W'(STEP_SAMPLES - 1) : step_reg;
    assign err_new  = sat32({measured_reg[POS_W-1], measured_reg}
                          - {target_reg[POS_W-1], target_reg});
    assign chg_new  = sat32({err_reg[POS_W-1], err_reg} - {prev_err_reg[POS_W-1], prev_err_reg});
    assign acc_sum  = {err_acc_reg[POS_W-1], err_acc_reg} + {err_reg[POS_W-1], err_reg};
    assign acc_new  = (acc_sum > SUM_MAX) ? SUM_MAX[POS_W-1:0]
                    : (acc_sum < SUM_MIN) ? SUM_MIN[POS_W-1:0] : acc_sum[POS_W-1:0];

    // Product sum and command
    assign prod_ext  = {{(SUM_W-MUL_P_W){prod_reg[MUL_P_W-1]}}, prod_reg};
    assign sum_neg   = -sum_reg;
    assign sum_shift = sum_neg >>> Q_SHIFT;

    always_comb begin
        if (sum_shift > CMD_MAX) begin
            cmd_next = CMD_MAX[CMD_W-1:0];
        end else if (sum_shift < CMD_MIN) begin
            cmd_next = CMD_MIN[CMD_W-1:0];
        end else begin
            cmd_next = sum_shift[CMD_W-1:0];
        end
    end

    always_comb begin
        case (state_reg)
            ST_MD:          sum_next = prod_ext;
            ST_MI, ST_SUM:  sum_next = sum_reg + prod_ext;
            default:        sum_next = sum_reg;
        endcase
    end

    // Division fix-up: remainder must land in [0, 100)
    assign quo_ext = {{(REM_W-QUO_W){quo_reg[QUO_W-1]}}, quo_reg};
    assign num_ext = {{(REM_W-DIVN_W){num_reg[DIVN_W-1]}}, num_reg};
    assign hund_q  = (quo_ext <<< 6) + (quo_ext <<< 5) + (quo_ext <<< 2);
    assign rem     = num_ext - hund_q;

    always_comb begin
        if (rem >= SCALE_DIV) begin
            quo_fix = quo_reg + QUO_W'(1);
        end else if (rem < 0) begin
            quo_fix = quo_reg - QUO_W'(1);
        end else begin
            quo_fix = quo_reg;
        end
        if (!win_reg) begin
            force_next = '0;
        end else if (quo_fix < FORCE_FLOOR) begin
            force_next = FORCE_FLOOR;
        end else begin
            force_next = quo_fix;
        end
    end

    // Multiplier operand select
    always_comb begin
        case (state_reg)
            ST_MP: begin
                mul_op.a = {1'b0, gain_p_reg};
                mul_op.b = err_reg;
            end
            ST_MD: begin
                mul_op.a = {1'b0, gain_d_reg};
                mul_op.b = chg_reg;
            end
            ST_MI: begin
                mul_op.a = {1'b0, gain_i_reg};
                mul_op.b = err_acc_reg;
            end
            ST_MS: begin
                mul_op.a = {{(MUL_A_W-STEP_W){1'b0}}, step_reg};
                mul_op.b = {{(MUL_B_W-CMD_W){cmd_reg[CMD_W-1]}}, cmd_reg};
            end
            ST_MQ: begin
                mul_op.a = RECIP_100;
                mul_op.b = {{(MUL_B_W-DIVN_W){prod_reg[DIVN_W-1]}}, prod_reg[DIVN_W-1:0]};
            end
            default: begin
                mul_op.a = '0;
                mul_op.b = '0;
            end
        endcase
    end

    // Sequencer
    always_comb begin
        case (state_reg)
            ST_IDLE:  state_next = in_fire ? ST_ERR : ST_IDLE;
            ST_ERR:   state_next = ST_STATE;
            ST_STATE: state_next = ST_MP;
            ST_MP:    state_next = ST_MD;
            ST_MD:    state_next = ST_MI;
            ST_MI:    state_next = ST_SUM;
            ST_SUM:   state_next = ST_CMD;
            ST_CMD:   state_next = ST_MS;
            ST_MS:    state_next = ST_MQ;
            ST_MQ:    state_next = ST_DIV;
            ST_DIV:   state_next = ST_FIX;
            ST_FIX:   state_next = fix_go ? ST_IDLE : ST_FIX;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Control state, configuration and controller history
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            gain_p_reg    <= '0;
            gain_d_reg    <= '0;
            gain_i_reg    <= '0;
            win_start_reg <= '0;
            win_end_reg   <= '0;
            prev_err_reg  <= '0;
            err_acc_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_FIX && fix_go) begin
                out_valid_reg <= 1'b1;
            end else if (out_fire) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_GAIN_P:       gain_p_reg    <= cfg_wdata;
                    CFG_GAIN_D:       gain_d_reg    <= cfg_wdata;
                    CFG_GAIN_I:       gain_i_reg    <= cfg_wdata;
                    CFG_WINDOW_START: win_start_reg <= cfg_wdata[STEP_W-1:0];
                    CFG_WINDOW_END:   win_end_reg   <= cfg_wdata[STEP_W-1:0];
                    default: ;
                endcase
            end
            if (state_reg == ST_STATE) begin
                prev_err_reg <= err_reg;
                err_acc_reg  <= acc_new;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            target_reg   <= s_tdata[POS_W-1:0];
            measured_reg <= s_tdata[2*POS_W-1:POS_W];
            step_reg     <= s_tdata[2*POS_W+STEP_W-1:2*POS_W];
        end
        if (state_reg == ST_ERR) begin
            err_reg  <= err_new;
            step_reg <= step_sat;
            win_reg  <= (step_sat > win_start_reg) && (step_sat <= win_end_reg);
        end
        if (state_reg == ST_STATE) begin
            chg_reg <= chg_new;
        end
        sum_reg <= sum_next;
        if (state_reg == ST_CMD) begin
            cmd_reg <= cmd_next;
        end
        if (state_reg == ST_MQ) begin
            num_reg <= prod_reg[DIVN_W-1:0];
        end
        if (state_reg == ST_DIV) begin
            quo_reg <= prod_reg[RECIP_SHIFT+QUO_W-1:RECIP_SHIFT];
        end
        if (state_reg == ST_FIX && fix_go) begin
            force_reg <= force_next;
        end
    end

    // Checks
    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> (state_reg == ST_ERR))
        else $error("accepted request did not start the sequence");

    assert property (@(posedge aclk) disable iff (!aresetn)
        ($signed(err_acc_reg) <= $signed(SUM_MAX[POS_W-1:0]))
        && ($signed(err_acc_reg) >= $signed(SUM_MIN[POS_W-1:0])))
        else $error("error sum outside its clamp");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MS) |-> ((cmd_reg <= $signed(CMD_MAX[CMD_W-1:0]))
                               && (cmd_reg >= $signed(CMD_MIN[CMD_W-1:0]))))
        else $error("command outside window clamp");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIX) && fix_go |-> (rem >= 0) && (rem < (SCALE_DIV + SCALE_DIV)))
        else $error("divide estimate off by more than one");

endmodule
